// ----- sv/tts_pkg.sv -----
// Shared types, constants and register codes for the tilt-to-servo PWM block.
`timescale 1ns / 1ps

package tts_pkg;

    localparam int COUNT_BITS_DEF = 14;
    localparam int POS_BITS_DEF   = 12;

    localparam int WIN_W  = 14;
    localparam int CFG_W  = 12;
    localparam int DATA_W = 14;
    localparam int IDX_W  = 3;

    localparam int RST_WINDOW   = 10000;
    localparam int RST_PERIOD   = 2000;
    localparam int RST_POS_MIN  = 60;
    localparam int RST_POS_MAX  = 240;
    localparam int RST_POS_SPAN = 180;
    localparam int RST_CAL_MIN  = 10000;

    localparam logic [IDX_W-1:0] REG_WINDOW   = 3'd0;
    localparam logic [IDX_W-1:0] REG_PERIOD   = 3'd1;
    localparam logic [IDX_W-1:0] REG_POS_MIN  = 3'd2;
    localparam logic [IDX_W-1:0] REG_POS_MAX  = 3'd3;
    localparam logic [IDX_W-1:0] REG_POS_SPAN = 3'd4;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_PWM    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CAL,
        ST_START1,
        ST_WAIT1,
        ST_START2,
        ST_WAIT2,
        ST_FIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic tick;
        logic cal;
        logic d1_start;
        logic d_clear;
        logic d1_latch;
        logic d2_start;
        logic d2_latch;
        logic finish;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic is_sample;
        logic win_close;
        logic span_zero;
        logic div_zero;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

// ----- sv/tilt_to_servo_pwm_core.sv -----
// Top level of the tilt-to-servo PWM block: controller plus datapath.
`timescale 1ns / 1ps

// Each input word is one tick: opcode 0 is a sensor sample carrying the
// accelerometer line level, opcode 1 is a PWM tick. Every accepted word
// yields exactly one result word with the servo pin level, the servo pulse
// width and a flag that marks the sample that closed a window.
// Words are taken one at a time. An ordinary tick passes through the execute
// and emit states before the next word is accepted; its result is registered
// in the emit state. A sample that closes a window runs up to two divisions on
// one shared restoring divider between calibration and the finish state, then
// goes to the emit state before the next word is taken.
// A new word is accepted while the previous result still waits in the output
// register; if the receiver stalls, the block finishes that word, holds its
// result until the output register is taken, and accepts no word meanwhile.
// Configuration is written through a plain write port and should only be
// written while the block is idle. Reset restores the configuration registers,
// clears the counters and calibration maximum, and sets the calibration minimum.
module tilt_to_servo_pwm_core #(
    parameter int COUNT_BITS = tts_pkg::COUNT_BITS_DEF,
    parameter int POS_BITS   = tts_pkg::POS_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [tts_pkg::IDX_W-1:0]  cfg_index,
    input  logic [tts_pkg::DATA_W-1:0] cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_opcode,
    input  logic                       s_accel_x_bit,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_servo_pin,
    output logic [POS_BITS-1:0]        m_servo_position,
    output logic                       m_window_done
);

    import tts_pkg::*;

    cmd_t    cmd;
    status_t status;

    tts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tts_datapath #(
        .COUNT_BITS (COUNT_BITS),
        .POS_BITS   (POS_BITS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_opcode         (s_opcode),
        .s_accel_x_bit    (s_accel_x_bit),
        .cmd              (cmd),
        .status           (status),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_servo_pin      (m_servo_pin),
        .m_servo_position (m_servo_position),
        .m_window_done    (m_window_done)
    );

endmodule

// ----- sv/tts_divider.sv -----
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module tts_divider #(
    parameter int N  = 14,
    parameter int DW = 14
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [N-1:0]  dividend,
    input  logic [DW-1:0] divisor,
    output logic [N-1:0]  quotient,
    output logic          done
);

    localparam int CW = (N > 1) ? $clog2(N) : 1;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [N-1:0]  quot_reg, quot_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [DW:0]   rem_shift;
    logic [DW:0]   rem_sub;

    assign rem_shift = {rem_reg, quot_reg[N-1]};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(N - 1);
            rem_next  = '0;
            quot_next = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (rem_shift >= {1'b0, dvs_reg}) begin
                rem_next  = rem_sub[DW-1:0];
                quot_next = {quot_reg[N-2:0], 1'b1};
            end else begin
                rem_next  = rem_shift[DW-1:0];
                quot_next = {quot_reg[N-2:0], 1'b0};
            end
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign quotient = quot_reg;
    assign done     = done_reg;

endmodule

// ----- sv/tts_datapath.sv -----
// Datapath: configuration registers, counters, calibration, scaling and output word register.
`timescale 1ns / 1ps

module tts_datapath #(
    parameter int COUNT_BITS = tts_pkg::COUNT_BITS_DEF,
    parameter int POS_BITS   = tts_pkg::POS_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [tts_pkg::IDX_W-1:0]  cfg_index,
    input  logic [tts_pkg::DATA_W-1:0] cfg_wdata,
    input  logic                       s_opcode,
    input  logic                       s_accel_x_bit,
    input  tts_pkg::cmd_t              cmd,
    output tts_pkg::status_t           status,
    input  logic                       m_ready,
    output logic                       m_valid,
    output logic                       m_servo_pin,
    output logic [POS_BITS-1:0]        m_servo_position,
    output logic                       m_window_done
);

    import tts_pkg::*;

    localparam int CMP_W = (COUNT_BITS > WIN_W) ? COUNT_BITS : WIN_W;
    localparam int PCW   = (POS_BITS > CFG_W) ? POS_BITS : CFG_W;
    localparam int DW    = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam int VW    = ((DW > POS_BITS) ? DW : POS_BITS) + 1;

    logic [WIN_W-1:0]      window_ticks_reg;
    logic [CFG_W-1:0]      period_reg;
    logic [CFG_W-1:0]      pos_min_reg;
    logic [CFG_W-1:0]      pos_max_reg;
    logic [CFG_W-1:0]      pos_span_reg;

    logic                  opcode_reg;
    logic                  bit_reg;

    logic [POS_BITS-1:0]   pwm_count_reg, pwm_count_next;
    logic [COUNT_BITS-1:0] window_count_reg, window_count_next;
    logic [COUNT_BITS-1:0] high_count_reg, high_count_next;
    logic [COUNT_BITS-1:0] cal_max_reg, cal_max_next;
    logic [COUNT_BITS-1:0] cal_min_reg, cal_min_next;
    logic [POS_BITS-1:0]   position_reg, position_next;
    logic                  pin_reg, pin_next;
    logic                  done_flag_reg, done_flag_next;
    logic [COUNT_BITS-1:0] div_reg, div_next;
    logic [COUNT_BITS-1:0] q_reg, q_next;

    logic                  m_valid_reg, m_valid_next;
    logic                  m_pin_reg;
    logic [POS_BITS-1:0]   m_pos_reg;
    logic                  m_done_reg;

    logic                  div_start;
    logic [COUNT_BITS-1:0] div_dividend;
    logic [DW-1:0]         div_divisor;
    logic [COUNT_BITS-1:0] div_quot;
    logic                  div_done;

    logic [VW-1:0]         val_sum;
    logic [VW-1:0]         val_hi;
    logic [VW-1:0]         val_lo;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_ticks_reg <= WIN_W'(RST_WINDOW);
            period_reg       <= CFG_W'(RST_PERIOD);
            pos_min_reg      <= CFG_W'(RST_POS_MIN);
            pos_max_reg      <= CFG_W'(RST_POS_MAX);
            pos_span_reg     <= CFG_W'(RST_POS_SPAN);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_WINDOW:   window_ticks_reg <= cfg_wdata[WIN_W-1:0];
                REG_PERIOD:   period_reg       <= cfg_wdata[CFG_W-1:0];
                REG_POS_MIN:  pos_min_reg      <= cfg_wdata[CFG_W-1:0];
                REG_POS_MAX:  pos_max_reg      <= cfg_wdata[CFG_W-1:0];
                REG_POS_SPAN: pos_span_reg     <= cfg_wdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            opcode_reg <= s_opcode;
            bit_reg    <= s_accel_x_bit;
        end
    end

    assign div_start    = cmd.d1_start | cmd.d2_start;
    assign div_dividend = cmd.d1_start ? (cal_max_reg - cal_min_reg)
                                       : (high_count_reg - cal_min_reg);
    assign div_divisor  = cmd.d1_start ? DW'(pos_span_reg) : DW'(div_reg);

    tts_divider #(
        .N  (COUNT_BITS),
        .DW (DW)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .done     (div_done)
    );

    always_comb begin
        val_sum = VW'(q_reg) + VW'(pos_min_reg);
        if (div_reg == '0) begin
            val_sum = VW'(pos_min_reg);
        end
        val_hi = (val_sum > VW'(pos_max_reg)) ? VW'(pos_max_reg) : val_sum;
        val_lo = (val_hi < VW'(pos_min_reg)) ? VW'(pos_min_reg) : val_hi;
    end

    always_comb begin
        pwm_count_next    = pwm_count_reg;
        window_count_next = window_count_reg;
        high_count_next   = high_count_reg;
        cal_max_next      = cal_max_reg;
        cal_min_next      = cal_min_reg;
        position_next     = position_reg;
        pin_next          = pin_reg;
        done_flag_next    = done_flag_reg;
        div_next          = div_reg;
        q_next            = q_reg;
        if (cmd.tick) begin
            done_flag_next = 1'b0;
            if (opcode_reg == OP_PWM) begin
                if (PCW'(pwm_count_reg) >= PCW'(period_reg)) begin
                    pwm_count_next = '0;
                end else begin
                    pwm_count_next = pwm_count_reg + 1'b1;
                end
                pin_next = (pwm_count_next < position_reg);
            end else begin
                if (bit_reg) begin
                    high_count_next = high_count_reg + 1'b1;
                end
                window_count_next = window_count_reg + 1'b1;
            end
        end
        if (cmd.cal) begin
            if (high_count_reg > cal_max_reg) begin
                cal_max_next = high_count_reg;
            end
            if (high_count_reg < cal_min_reg) begin
                cal_min_next = high_count_reg;
            end
        end
        if (cmd.d_clear) begin
            div_next = '0;
        end
        if (cmd.d1_latch) begin
            div_next = div_quot;
        end
        if (cmd.d2_latch) begin
            q_next = div_quot;
        end
        if (cmd.finish) begin
            position_next     = val_lo[POS_BITS-1:0];
            window_count_next = '0;
            high_count_next   = '0;
            done_flag_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwm_count_reg    <= '0;
            window_count_reg <= '0;
            high_count_reg   <= '0;
            cal_max_reg      <= '0;
            cal_min_reg      <= COUNT_BITS'(RST_CAL_MIN);
            position_reg     <= '0;
            pin_reg          <= 1'b0;
            done_flag_reg    <= 1'b0;
        end else begin
            pwm_count_reg    <= pwm_count_next;
            window_count_reg <= window_count_next;
            high_count_reg   <= high_count_next;
            cal_max_reg      <= cal_max_next;
            cal_min_reg      <= cal_min_next;
            position_reg     <= position_next;
            pin_reg          <= pin_next;
            done_flag_reg    <= done_flag_next;
        end
        div_reg <= div_next;
        q_reg   <= q_next;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (cmd.emit) begin
            m_pin_reg  <= pin_reg;
            m_pos_reg  <= position_reg;
            m_done_reg <= done_flag_reg;
        end
    end

    assign status.is_sample = (opcode_reg == OP_SAMPLE);
    assign status.win_close = (CMP_W'(window_count_reg) >= CMP_W'(window_ticks_reg));
    assign status.span_zero = (pos_span_reg == '0);
    assign status.div_zero  = (div_reg == '0);
    assign status.div_done  = div_done;
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid          = m_valid_reg;
    assign m_servo_pin      = m_pin_reg;
    assign m_servo_position = m_pos_reg;
    assign m_window_done    = m_done_reg;

endmodule

// ----- sv/tts_ctrl.sv -----
// Controller state machine that sequences ticks, window evaluation and output.
`timescale 1ns / 1ps

module tts_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tts_pkg::status_t status,
    output tts_pkg::cmd_t    cmd
);

    import tts_pkg::*;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (status.is_sample && status.win_close) begin
                    state_next = ST_CAL;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_CAL: begin
                state_next = ST_START1;
            end
            ST_START1: begin
                state_next = status.span_zero ? ST_FIN : ST_WAIT1;
            end
            ST_WAIT1: begin
                if (status.div_done) begin
                    state_next = ST_START2;
                end
            end
            ST_START2: begin
                state_next = status.div_zero ? ST_FIN : ST_WAIT2;
            end
            ST_WAIT2: begin
                if (status.div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_EXEC: begin
                cmd.tick = !(status.is_sample && status.win_close);
            end
            ST_CAL: begin
                cmd.cal = 1'b1;
            end
            ST_START1: begin
                cmd.d_clear  = status.span_zero;
                cmd.d1_start = !status.span_zero;
            end
            ST_WAIT1: begin
                cmd.d1_latch = status.div_done;
            end
            ST_START2: begin
                cmd.d2_start = !status.div_zero;
            end
            ST_WAIT2: begin
                cmd.d2_latch = status.div_done;
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- verif/tilt_to_servo_pwm_core_tb.sv -----
// Self-checking testbench for the tilt-to-servo PWM core with random handshake stalls.
`timescale 1ns / 1ps

module tilt_to_servo_pwm_core_tb;
    import tts_pkg::*;

    localparam int PW = POS_BITS_DEF;
    localparam int CW = COUNT_BITS_DEF;

    typedef struct {
        logic          pin;
        logic [PW-1:0] pos;
        logic          done;
    } servo_word_t;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic [IDX_W-1:0]  cfg_index     = '0;
    logic [DATA_W-1:0] cfg_wdata     = '0;
    logic              s_valid       = 1'b0;
    logic              s_ready;
    logic              s_opcode      = OP_SAMPLE;
    logic              s_accel_x_bit = 1'b0;
    logic              m_valid;
    logic              m_ready       = 1'b0;
    logic              m_servo_pin;
    logic [PW-1:0]     m_servo_position;
    logic              m_window_done;

    // Shadow of the configuration registers.
    logic [WIN_W-1:0] cfg_window  = WIN_W'(RST_WINDOW);
    logic [CFG_W-1:0] cfg_period  = CFG_W'(RST_PERIOD);
    logic [CFG_W-1:0] cfg_pos_min = CFG_W'(RST_POS_MIN);
    logic [CFG_W-1:0] cfg_pos_max = CFG_W'(RST_POS_MAX);
    logic [CFG_W-1:0] cfg_span    = CFG_W'(RST_POS_SPAN);

    // Shadow of the block's counters and calibration.
    logic [PW-1:0] pwm_cnt  = '0;
    logic [CW-1:0] win_cnt  = '0;
    logic [CW-1:0] high_cnt = '0;
    logic [CW-1:0] cal_hi   = '0;
    logic [CW-1:0] cal_lo   = CW'(RST_CAL_MIN);
    logic [PW-1:0] pos_q    = '0;
    logic          pin_q    = 1'b0;

    servo_word_t expected_words[$];
    int          mismatches = 0;
    int          ticks_sent = 0;
    int          stall_left = 0;
    bit          quiet      = 1'b0;

    tilt_to_servo_pwm_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_accel_x_bit   (s_accel_x_bit),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_servo_pin     (m_servo_pin),
        .m_servo_position(m_servo_position),
        .m_window_done   (m_window_done)
    );

    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic servo_word_t step_servo(logic op, logic accel);
        servo_word_t w;
        int diff;
        int div;
        int val;
        w.done = 1'b0;
        if (op == OP_SAMPLE) begin
            if (win_cnt >= cfg_window) begin
                if (high_cnt > cal_hi) cal_hi = high_cnt;
                if (high_cnt < cal_lo) cal_lo = high_cnt;
                diff = int'(high_cnt - cal_lo);
                div = 0;
                if (cfg_span != 0 && cal_hi >= cal_lo)
                    div = int'((cal_hi - cal_lo) / cfg_span);
                if (div == 0) val = int'(cfg_pos_min);
                else val = diff / div + int'(cfg_pos_min);
                if (val > int'(cfg_pos_max)) val = int'(cfg_pos_max);
                if (val < int'(cfg_pos_min)) val = int'(cfg_pos_min);
                pos_q    = val[PW-1:0];
                win_cnt  = '0;
                high_cnt = '0;
                w.done   = 1'b1;
            end else begin
                if (accel) high_cnt = high_cnt + 1'b1;
                win_cnt = win_cnt + 1'b1;
            end
        end else begin
            if (pwm_cnt >= cfg_period) pwm_cnt = '0;
            else pwm_cnt = pwm_cnt + 1'b1;
            pin_q = (pwm_cnt < pos_q);
        end
        w.pin = pin_q;
        w.pos = pos_q;
        return w;
    endfunction

    task automatic report_error(input string msg);
        if (mismatches < 100) $display("%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_tick(input logic op, input logic accel);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_accel_x_bit <= accel;
        do @(posedge aclk); while (!s_ready);
        expected_words.push_back(step_servo(op, accel));
        ticks_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[DATA_W-1:0];
        @(posedge aclk);
    endtask

    task automatic program_servo(input int window, input int period, input int pmin,
                                 input int pmax, input int span);
        wait_idle();
        write_reg(REG_WINDOW, window);
        write_reg(REG_PERIOD, period);
        write_reg(REG_POS_MIN, pmin);
        write_reg(REG_POS_MAX, pmax);
        write_reg(REG_POS_SPAN, span);
        cfg_wr_en   <= 1'b0;
        cfg_window  = window[WIN_W-1:0];
        cfg_period  = period[CFG_W-1:0];
        cfg_pos_min = pmin[CFG_W-1:0];
        cfg_pos_max = pmax[CFG_W-1:0];
        cfg_span    = span[CFG_W-1:0];
        @(posedge aclk);
    endtask

    task automatic test_reset_state();
        quiet = 1'b1;
        send_tick(OP_PWM, 1'b0);
        send_tick(OP_PWM, 1'b1);
        send_tick(OP_SAMPLE, 1'b1);
        send_tick(OP_SAMPLE, 1'b0);
        send_tick(OP_PWM, 1'b0);
    endtask

    // A zero window closes on every sample, and a zero span forces pos_min.
    task automatic test_zero_window_and_span();
        program_servo(0, 2, 7, 4095, 0);
        quiet = 1'b0;
        send_tick(OP_SAMPLE, 1'b1);
        send_tick(OP_SAMPLE, 1'b0);
        repeat (4) send_tick(OP_PWM, 1'b1);
    endtask

    // With pos_min above pos_max the position lands on pos_min; a zero period
    // holds the PWM counter at zero.
    task automatic test_inverted_limits();
        program_servo(3, 0, 4095, 0, 1);
        repeat (3) send_tick(OP_SAMPLE, 1'b1);
        send_tick(OP_SAMPLE, 1'b0);
        repeat (2) send_tick(OP_PWM, 1'b0);
    endtask

    task automatic test_widest_settings();
        program_servo(16383, 4095, 0, 4095, 4095);
        send_tick(OP_SAMPLE, 1'b1);
        send_tick(OP_SAMPLE, 1'b0);
        repeat (3) send_tick(OP_PWM, 1'b1);
    endtask

    task automatic test_random_windows();
        int start;
        int len;
        int duty;
        int r;
        int window;
        int period;
        int pmax;
        int span;
        start = ticks_sent;
        duty = 50;
        while (ticks_sent - start < 1750) begin
            r = $urandom_range(0, 9);
            if (r == 0) window = 0;
            else if (r < 8) window = $urandom_range(1, 40);
            else if (r == 8) window = $urandom_range(41, 150);
            else window = $urandom_range(1, 3);
            r = $urandom_range(0, 9);
            if (r < 8) period = $urandom_range(0, 30);
            else if (r == 8) period = $urandom_range(31, 4095);
            else period = 4095;
            pmax = ($urandom_range(0, 9) == 0) ? 4095 : $urandom_range(0, 50);
            span = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 4095)
                                                : $urandom_range(0, 6);
            program_servo(window, period, $urandom_range(0, 20), pmax, span);
            quiet = ($urandom_range(0, 4) == 0);
            len = $urandom_range(80, 240);
            repeat (len) begin
                if (win_cnt == 0) duty = $urandom_range(0, 4) * 25;
                if ($urandom_range(0, 99) < 60)
                    send_tick(OP_SAMPLE, $urandom_range(0, 99) < duty);
                else
                    send_tick(OP_PWM, 1'($urandom_range(0, 1)));
            end
        end
        quiet = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        servo_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_error($sformatf("result word with nothing expected (position %0d)",
                                       m_servo_position));
            end else begin
                want = expected_words.pop_front();
                if (m_servo_pin !== want.pin)
                    report_error($sformatf("servo_pin got %0b, expected %0b",
                                           m_servo_pin, want.pin));
                if (m_servo_position !== want.pos)
                    report_error($sformatf("servo_position got %0d, expected %0d",
                                           m_servo_position, want.pos));
                if (m_window_done !== want.done)
                    report_error($sformatf("window_done got %0b, expected %0b",
                                           m_window_done, want.done));
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_zero_window_and_span();
        test_inverted_limits();
        test_widest_settings();
        test_random_windows();
        wait_idle();
        repeat (50) @(posedge aclk);
        if (mismatches == 0) begin
            $display("** tilt_to_servo_pwm_core: PASSED **");
        end else begin
            $display("** tilt_to_servo_pwm_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d result words outstanding", expected_words.size());
        $display("** tilt_to_servo_pwm_core: FAILED **");
        $finish;
    end

endmodule

// ----- tilt_to_servo_pwm_core.f -----
sv/tts_pkg.sv
sv/tts_divider.sv
sv/tts_datapath.sv
sv/tts_ctrl.sv
sv/tilt_to_servo_pwm_core.sv
verif/tilt_to_servo_pwm_core_tb.sv
